// File: rtl/core/per_source_message_statistics_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-source message statistics block
// Concurrent checks sampled on the rising clock edge and disabled while the
// asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_MESSAGE_STATISTICS_TOP_ASSERT_SVH
`define PER_SOURCE_MESSAGE_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold as well.
`define PSMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PSMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/psms_pkg.sv
// ----------------------------------------------------------------------------
// psms_pkg
// Types and constants shared by the per-source message statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psms_pkg;

  // field widths
  localparam int RANK_W  = 8;
  localparam int TIME_W  = 48;
  localparam int STAT_W  = 64;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 2;
  localparam int FRAC_W  = 16;
  // divider iteration counter: one quotient bit per cycle
  localparam int DIV_CNT_W = 6;

  // configuration register indexes
  localparam logic CFG_STAT_SEL = 1'b0;
  localparam logic CFG_COMB_SEL = 1'b1;

  // item kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    STAT_COUNT    = 2'd0,
    STAT_LENGTH   = 2'd1,
    STAT_DURATION = 2'd2,
    STAT_RATE     = 2'd3
  } stat_sel_e;

  typedef enum logic [1:0] {
    COMB_MIN = 2'd0,
    COMB_MAX = 2'd1,
    COMB_AVG = 2'd2,
    COMB_SUM = 2'd3
  } comb_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DIV_RATE,
    ST_FOLD,
    ST_REPORT,
    ST_DIV_AVG,
    ST_EMIT
  } state_e;

  // access to the per-rank tables
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [RANK_W-1:0] rank;
    logic [STAT_W-1:0] wr_stat;
    logic [CNT_W-1:0]  wr_count;
  } store_req_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/per_source_message_statistics_top.sv
// ----------------------------------------------------------------------------
// per_source_message_statistics_top
// Usage: items enter on the input channel (valid/stall); each gives exactly
// one result on the output channel (valid/stall). A record item folds a
// count, length, duration or rate into the source rank's entry; a read item
// reports the entry. Registers are written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i while no item is in flight.
// One item is worked on at a time; in_stall_o is high from acceptance until
// its result is loaded into the output register, so the next item can be
// accepted while that result still waits to be taken.
// Steps: look up the entry; for an applicable record, form the rate by
// division if needed and fold the value in; then report the entry, dividing
// it by the count for an average, and emit the result. Each division runs on
// the bit-serial divider, one quotient bit a cycle.
// Reset clears both registers and every table row (row valid bits), so all
// entries read as zero. A stalled receiver holds the output register; a
// finished second result waits in the emit step until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "per_source_message_statistics_top_assert.svh"

module per_source_message_statistics_top #(
  parameter int MAX_RANKS = 256
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_we_i,
  input  wire                          cfg_idx_i,
  input  wire  [psms_pkg::CFG_W-1:0]   cfg_wdata_i,
  // input channel
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          kind_i,
  input  wire  [psms_pkg::RANK_W-1:0]  source_rank_i,
  input  wire  [psms_pkg::TIME_W-1:0]  bytes_sent_i,
  input  wire  [psms_pkg::TIME_W-1:0]  send_time_i,
  input  wire  [psms_pkg::TIME_W-1:0]  recv_time_i,
  input  wire                          applicable_i,
  // output channel
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [psms_pkg::RANK_W-1:0]  result_rank_o,
  output logic [psms_pkg::STAT_W-1:0]  stat_value_o,
  output logic [psms_pkg::CNT_W-1:0]   message_count_o,
  output logic                         rate_saturated_o
);

  import psms_pkg::*;

  localparam int DEPTH = (MAX_RANKS < 256) ? MAX_RANKS : 256;
  localparam logic [16:0] RANK_LIMIT = 17'(MAX_RANKS);
  localparam logic [STAT_W-1:0] STAT_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // configuration registers
  stat_sel_e stat_sel_q;
  comb_sel_e comb_sel_q;

  // control
  state_e state_q, state_d;

  // item registers
  logic              kind_q;
  logic [RANK_W-1:0] rank_q;
  logic [TIME_W-1:0] bytes_q;
  logic [TIME_W-1:0] dur_q;
  logic              appl_q;
  logic              rank_ok_q;
  logic [STAT_W-1:0] stat_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [STAT_W-1:0] val_q;
  logic [STAT_W-1:0] rep_q;
  logic              sat_q;

  // output register
  logic              out_valid_q;
  logic [RANK_W-1:0] out_rank_q;
  logic [STAT_W-1:0] out_stat_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_sat_q;

  // sub-block wiring
  store_req_t        store_req;
  logic [STAT_W-1:0] rd_stat;
  logic [CNT_W-1:0]  rd_count;
  logic              div_start;
  logic [STAT_W-1:0] div_dividend;
  logic [TIME_W-1:0] div_divisor;
  logic [STAT_W-1:0] div_quotient;
  div_stat_t         div_stat;

  // datapath helpers
  logic              in_xfer;
  logic              do_rec;
  logic              emit_load;
  logic [STAT_W:0]   sum_ext;
  logic [STAT_W-1:0] sum_sat;
  logic [STAT_W-1:0] fold_stat;
  logic [CNT_W-1:0]  fold_cnt;
  logic              avg_div;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign do_rec    = rank_ok_q && (kind_q == KIND_RECORD) && appl_q;
  assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign avg_div   = (comb_sel_q == COMB_AVG) && (cnt_q != '0);

  // saturating add of the new value (or one, for counting)
  always_comb begin
    if (stat_sel_q == STAT_COUNT) begin
      sum_ext = {1'b0, stat_q} + (STAT_W + 1)'(1);
    end else begin
      sum_ext = {1'b0, stat_q} + {1'b0, val_q};
    end
    sum_sat = sum_ext[STAT_W] ? STAT_MAX : sum_ext[STAT_W-1:0];
  end

  // fold the new value into the entry
  always_comb begin
    fold_stat = stat_q;
    fold_cnt  = cnt_q;
    if (stat_sel_q == STAT_COUNT) begin
      fold_stat = sum_sat;
    end else begin
      case (comb_sel_q)
        COMB_MIN: begin
          if (stat_q == '0 || val_q < stat_q) fold_stat = val_q;
        end
        COMB_MAX: begin
          if (stat_q == '0 || val_q > stat_q) fold_stat = val_q;
        end
        COMB_AVG: begin
          fold_stat = sum_sat;
          if (cnt_q != CNT_MAX) fold_cnt = cnt_q + CNT_W'(1);
        end
        default: begin
          fold_stat = sum_sat;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (!do_rec) begin
          state_d = ST_REPORT;
        end else if (stat_sel_q == STAT_RATE && dur_q != '0) begin
          state_d = ST_DIV_RATE;
        end else begin
          state_d = ST_FOLD;
        end
      end
      ST_DIV_RATE: begin
        if (div_stat.done) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        state_d = avg_div ? ST_DIV_AVG : ST_EMIT;
      end
      ST_DIV_AVG: begin
        if (div_stat.done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o         = 1'b1;
    store_req.rd_en    = 1'b0;
    store_req.wr_en    = 1'b0;
    store_req.rank     = rank_q;
    store_req.wr_stat  = fold_stat;
    store_req.wr_count = fold_cnt;
    div_start          = 1'b0;
    div_dividend       = {bytes_q, {FRAC_W{1'b0}}};
    div_divisor        = dur_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        store_req.rd_en = in_valid_i;
        store_req.rank  = source_rank_i;
      end
      ST_LOOK: begin
        div_start = do_rec && (stat_sel_q == STAT_RATE) && (dur_q != '0);
      end
      ST_FOLD: begin
        store_req.wr_en = 1'b1;
      end
      ST_REPORT: begin
        div_start    = avg_div;
        div_dividend = stat_q;
        div_divisor  = {{(TIME_W - CNT_W){1'b0}}, cnt_q};
      end
      default: begin
      end
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      stat_sel_q <= STAT_COUNT;
      comb_sel_q <= COMB_MIN;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_STAT_SEL: stat_sel_q <= stat_sel_e'(cfg_wdata_i);
          CFG_COMB_SEL: comb_sel_q <= comb_sel_e'(cfg_wdata_i);
          default: begin
          end
        endcase
      end
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q    <= kind_i;
      rank_q    <= source_rank_i;
      bytes_q   <= bytes_sent_i;
      appl_q    <= applicable_i;
      rank_ok_q <= ({9'd0, source_rank_i} < RANK_LIMIT);
      dur_q     <= (recv_time_i >= send_time_i) ? (recv_time_i - send_time_i) : '0;
      sat_q     <= 1'b0;
    end
    case (state_q)
      ST_LOOK: begin
        stat_q <= rank_ok_q ? rd_stat  : '0;
        cnt_q  <= rank_ok_q ? rd_count : '0;
        case (stat_sel_q)
          STAT_LENGTH:   val_q <= {{(STAT_W - TIME_W){1'b0}}, bytes_q};
          STAT_DURATION: val_q <= {{(STAT_W - TIME_W){1'b0}}, dur_q};
          default: begin
            val_q <= STAT_MAX;
            sat_q <= do_rec && (stat_sel_q == STAT_RATE) && (dur_q == '0);
          end
        endcase
      end
      ST_DIV_RATE: begin
        if (div_stat.done) val_q <= div_quotient;
      end
      ST_FOLD: begin
        stat_q <= fold_stat;
        cnt_q  <= fold_cnt;
      end
      ST_REPORT: begin
        rep_q <= stat_q;
      end
      ST_DIV_AVG: begin
        if (div_stat.done) rep_q <= div_quotient;
      end
      default: begin
      end
    endcase
  end

  // output register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_rank_q <= rank_q;
      out_stat_q <= rep_q;
      out_cnt_q  <= cnt_q;
      out_sat_q  <= sat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_rank_o    = out_rank_q;
  assign stat_value_o     = out_stat_q;
  assign message_count_o  = out_cnt_q;
  assign rate_saturated_o = out_sat_q;

  psms_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (store_req),
    .rd_stat_o  (rd_stat),
    .rd_count_o (rd_count)
  );

  psms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .stat_o     (div_stat)
  );

  // checks
  `PSMS_ASSERT_NOW(a_div_start_idle, clk_i, rst_ni, div_start, !div_stat.busy, "divider restarted while busy")
  `PSMS_ASSERT_NEXT(a_rate_to_fold, clk_i, rst_ni, (state_q == ST_DIV_RATE) && div_stat.done, state_q == ST_FOLD, "rate quotient not folded")
  `PSMS_ASSERT_NOW(a_bad_rank_zero, clk_i, rst_ni, (state_q == ST_EMIT) && !rank_ok_q, (rep_q == '0) && (cnt_q == '0) && !sat_q, "out-of-range rank not reported as zero")
  `PSMS_ASSERT_NOW(a_sat_rate_only, clk_i, rst_ni, (state_q == ST_EMIT) && sat_q, (stat_sel_q == STAT_RATE) && (kind_q == KIND_RECORD), "saturation flag outside a rate record")
  `PSMS_ASSERT_NOW(a_no_write_bad_rank, clk_i, rst_ni, store_req.wr_en, rank_ok_q && do_rec, "table written for an item that must not change it")

endmodule

`default_nettype wire

// File: rtl/core/psms_div.sv
// ----------------------------------------------------------------------------
// psms_div
// Radix-2 restoring divider: 64-bit dividend, 48-bit divisor. The dividend
// shifts out one bit per cycle while the quotient shifts in behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psms_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [psms_pkg::STAT_W-1:0]  dividend_i,
  input  wire  [psms_pkg::TIME_W-1:0]  divisor_i,
  output logic [psms_pkg::STAT_W-1:0]  quotient_o,
  output psms_pkg::div_stat_t          stat_o
);

  import psms_pkg::*;

  logic [STAT_W-1:0]    quo_q, quo_d;
  logic [TIME_W-1:0]    rem_q, rem_d;
  logic [TIME_W-1:0]    dsr_q, dsr_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [TIME_W:0]      trial;
  logic                 fits;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_q, quo_q[STAT_W-1]} - {1'b0, dsr_q};
    fits  = ({rem_q, quo_q[STAT_W-1]} >= {1'b0, dsr_q});
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[STAT_W-2:0], fits};
      rem_d = fits ? trial[TIME_W-1:0] : {rem_q[TIME_W-2:0], quo_q[STAT_W-1]};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// File: rtl/core/psms_store.sv
// ----------------------------------------------------------------------------
// psms_store
// Per-rank statistic and message count tables. One access per cycle, read
// data registered; a row valid bit makes unwritten rows read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psms_store #(
  parameter int DEPTH = 256
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  psms_pkg::store_req_t         req_i,
  output logic [psms_pkg::STAT_W-1:0]  rd_stat_o,
  output logic [psms_pkg::CNT_W-1:0]   rd_count_o
);

  import psms_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [STAT_W-1:0] stat_mem  [DEPTH];
  logic [CNT_W-1:0]  count_mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [STAT_W-1:0] rd_stat_q;
  logic [CNT_W-1:0]  rd_count_q;
  logic              rd_valid_q;
  logic [IDX_W-1:0]  idx;

  assign idx = req_i.rank[IDX_W-1:0];

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      stat_mem[idx]  <= req_i.wr_stat;
      count_mem[idx] <= req_i.wr_count;
    end
    if (req_i.rd_en) begin
      rd_stat_q  <= stat_mem[idx];
      rd_count_q <= count_mem[idx];
    end
  end

  // row valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[idx] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[idx];
      end
    end
  end

  assign rd_stat_o  = rd_valid_q ? rd_stat_q  : '0;
  assign rd_count_o = rd_valid_q ? rd_count_q : '0;

endmodule

`default_nettype wire
